>>> rtl/chol_pkg.sv
// Shared types, constants and helpers for the Cholesky linear solver.
// No dependencies; imported by every module of the block.
package chol_pkg;

    localparam int DATA_W        = 32;
    localparam int CNT_W         = 4;   // loop counters hold 0..8
    localparam int RESULT_CAP    = 8;
    localparam int DEF_MAX_DIM   = 8;
    localparam int DEF_FRAC_BITS = 16;
    localparam int SIZE_W        = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd5;

    typedef enum logic [1:0] {
        ACT_WR_MATRIX = 2'd0,
        ACT_WR_RHS    = 2'd1,
        ACT_START     = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef enum logic {
        DSU_DIV  = 1'b0,
        DSU_SQRT = 1'b1
    } t_dsu_op;

    // Control word for the multiply-accumulate unit.
    typedef struct packed {
        logic load;  // accumulator takes the start value
        logic mul;   // product register takes a * b
        logic acc;   // accumulator adds or subtracts the rounded product
        logic sub;   // subtract instead of add
    } t_mac_ctl;

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

>>> rtl/chol_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, rounded to
// nearest, added to or subtracted from a 64-bit accumulator. Uses chol_pkg.
module chol_mac import chol_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [63:0]       i_init,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic signed [DATA_W-1:0] o_sat
);

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [63:0] w_rnd;

    assign w_rnd = (r_prod + HALF) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= 64'(i_a) * 64'(i_b);
        end
        if (i_ctl.load) begin
            r_acc <= i_init;
        end else if (i_ctl.acc) begin
            r_acc <= i_ctl.sub ? r_acc - w_rnd : r_acc + w_rnd;
        end
    end

    assign o_sat = f_sat32(r_acc);

endmodule

>>> rtl/chol_dsu.sv
// Iterative divide / square-root unit: restoring division one quotient bit
// per cycle, digit-by-digit square root one root bit per cycle. Uses chol_pkg.
module chol_dsu import chol_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_dsu_op                  i_op,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_result
);

    localparam int NW  = DATA_W + FRAC_BITS;
    localparam int RW  = NW + (NW % 2);
    localparam int RB  = RW / 2;
    localparam int RMW = (RB + 2 > DATA_W + 1) ? RB + 2 : DATA_W + 1;
    localparam int CW  = $clog2(RW + 1);

    logic              r_busy;
    t_dsu_op           r_op;
    logic [CW-1:0]     r_cnt;
    logic [RW-1:0]     r_sh;
    logic [RMW-1:0]    r_rem;
    logic [RB-1:0]     r_root;
    logic [DATA_W-1:0] r_dm;
    logic              r_neg;
    logic              r_done;
    logic signed [DATA_W-1:0] r_res;

    logic [DATA_W-1:0] w_nm;
    logic [DATA_W-1:0] w_dmag;
    logic [RMW-1:0]    w_div_rem;
    logic              w_div_ge;
    logic [RMW-1:0]    w_sq_rem;
    logic [RMW-1:0]    w_sq_trial;
    logic              w_sq_ge;

    assign w_nm   = i_num[DATA_W-1] ? DATA_W'(-i_num) : DATA_W'(i_num);
    assign w_dmag = i_den[DATA_W-1] ? DATA_W'(-i_den) : DATA_W'(i_den);

    assign w_div_rem  = {r_rem[RMW-2:0], r_sh[RW-1]};
    assign w_div_ge   = w_div_rem >= RMW'(r_dm);
    assign w_sq_rem   = {r_rem[RMW-3:0], r_sh[RW-1:RW-2]};
    assign w_sq_trial = RMW'({r_root, 2'b01});
    assign w_sq_ge    = w_sq_rem >= w_sq_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_op   <= i_op;
                r_rem  <= '0;
                r_root <= '0;
                r_dm   <= w_dmag;
                r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
                if (i_op == DSU_SQRT) begin
                    r_sh   <= RW'(DATA_W'(i_num)) << FRAC_BITS;
                    r_cnt  <= CW'(RB);
                    r_busy <= 1'b1;
                end else if (i_den == '0) begin
                    // Division by zero saturates toward the numerator's sign.
                    if (i_num > 0) begin
                        r_res <= 32'sh7FFF_FFFF;
                    end else if (i_num < 0) begin
                        r_res <= 32'sh8000_0000;
                    end else begin
                        r_res <= '0;
                    end
                    r_done <= 1'b1;
                end else begin
                    r_sh   <= RW'(w_nm) << FRAC_BITS;
                    r_cnt  <= CW'(RW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_op == DSU_SQRT) begin
                    r_rem  <= w_sq_ge ? w_sq_rem - w_sq_trial : w_sq_rem;
                    r_root <= {r_root[RB-2:0], w_sq_ge};
                    r_sh   <= r_sh << 2;
                end else begin
                    r_rem <= w_div_ge ? w_div_rem - RMW'(r_dm) : w_div_rem;
                    r_sh  <= {r_sh[RW-2:0], w_div_ge};
                end
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                if (r_op == DSU_SQRT) begin
                    r_res <= DATA_W'(r_root);
                end else if (r_neg) begin
                    if ((|r_sh[RW-1:DATA_W]) || (r_sh[DATA_W-1] && |r_sh[DATA_W-2:0])) begin
                        r_res <= 32'sh8000_0000;
                    end else begin
                        r_res <= DATA_W'(-r_sh[DATA_W-1:0]);
                    end
                end else if (|r_sh[RW-1:DATA_W-1]) begin
                    r_res <= 32'sh7FFF_FFFF;
                end else begin
                    r_res <= DATA_W'(r_sh[DATA_W-1:0]);
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> rtl/cholesky_linear_solver_unit.sv
// Top level of the Cholesky linear solver: stores, sequencer and output.
// Depends on chol_pkg, chol_mac and chol_dsu.
//
// The block loads a symmetric matrix A and a right-hand side b one element per
// transaction, then on a start transaction solves A x = b in signed fixed point
// (FRAC_BITS fraction bits, 32-bit words). It builds the upper factor U with
// A = U^T U, runs forward substitution U^T y = b and back substitution U x = y,
// and then streams out one transaction per row i: i, x_i and the residual
// (A x - b)_i, all saturated, with tlast on the final row and tuser set when
// any pivot was not positive before its square root. A solve is sequential
// and the input is not ready until the last result has been taken: every
// value goes through one shared multiply-accumulate unit and one shared
// divide / square-root unit.
// There is no clearing pass after reset; matrix and right-hand-side entries
// must be written before a solve reads them.
module cholesky_linear_solver_unit import chol_pkg::*; #(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,  // row[2:0], col[5:3], value[37:6], zero fill
    input  logic [1:0]        s_axis_tuser,  // action[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [71:0]       m_axis_tdata,  // index[2:0], solution[34:3], residual[66:35]
    output logic [0:0]        m_axis_tuser,  // not_positive[0]
    output logic              m_axis_tlast
);

    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int VW    = $clog2(MAX_DIM);
    localparam int N_CAP = (MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_LOAD, S_TRD, S_TMUL, S_TACC,
        S_FIN, S_DRD, S_DGO, S_DWAIT, S_EMIT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_FAC, PH_FWD, PH_BCK, PH_RES
    } t_phase;

    function automatic logic [AW-1:0] f_addr(input logic [CNT_W-1:0] r,
                                             input logic [CNT_W-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Stores: matrix, upper factor (two read ports), rhs, and one vector that
    // holds y after the forward pass and is overwritten in place by x.
    logic signed [DATA_W-1:0] r_mem_a [MAX_DIM*MAX_DIM];
    logic signed [DATA_W-1:0] r_mem_u [MAX_DIM*MAX_DIM];
    logic signed [DATA_W-1:0] r_mem_b [MAX_DIM];
    logic signed [DATA_W-1:0] r_mem_v [MAX_DIM];

    logic signed [DATA_W-1:0] r_a_q, r_u0_q, r_u1_q, r_b_q, r_v_q;

    logic [SIZE_W-1:0] r_size;
    t_state            r_state;
    t_phase            r_phase;
    logic [CNT_W-1:0]  r_n, r_i, r_j, r_k;
    logic              r_flag;
    logic              r_m_valid;
    logic [2:0]        r_m_index;
    logic signed [DATA_W-1:0] r_m_sol, r_m_res;
    logic              r_m_last;

    logic              w_in_acc;
    t_action           w_act;
    logic [2:0]        w_row, w_col;
    logic signed [DATA_W-1:0] w_value;

    logic [AW-1:0]     w_a_addr, w_u0_addr, w_u1_addr, w_u_waddr;
    logic [VW-1:0]     w_v_addr;
    logic              w_u_we, w_v_we;
    logic signed [DATA_W-1:0] w_u_wdata;

    t_mac_ctl          w_mac_ctl;
    logic signed [63:0] w_init;
    logic signed [DATA_W-1:0] w_mac_a, w_mac_b, w_sat;

    logic              w_dsu_start;
    t_dsu_op           w_dsu_op;
    logic              w_dsu_done;
    logic signed [DATA_W-1:0] w_dsu_res;

    logic [CNT_W-1:0]  w_kstart, w_kend, w_k_inc;
    t_phase            w_adv_phase;
    logic [CNT_W-1:0]  w_adv_i, w_adv_j;
    logic              w_sat_nonpos;

    assign w_act    = t_action'(s_axis_tuser);
    assign w_row    = s_axis_tdata[2:0];
    assign w_col    = s_axis_tdata[5:3];
    assign w_value  = s_axis_tdata[37:6];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_k_inc  = r_k + 1'b1;
    assign w_sat_nonpos = (w_sat <= 0);

    // Read address selection by phase and step.
    always_comb begin
        w_a_addr  = (r_state == S_INIT) ? f_addr(r_i, r_j) : f_addr(r_i, r_k);
        w_u1_addr = f_addr(r_k, r_j);
        if (r_state == S_DRD) begin
            w_u0_addr = f_addr(r_i, r_i);
        end else if (r_phase == PH_BCK) begin
            w_u0_addr = f_addr(r_i, r_k);
        end else begin
            w_u0_addr = f_addr(r_k, r_i);
        end
        w_v_addr = (r_state == S_INIT || r_state == S_FIN) ? VW'(r_i) : VW'(r_k);
    end

    // Term range and start value of the element being computed.
    always_comb begin
        w_kstart = (r_phase == PH_BCK) ? r_i + 1'b1 : '0;
        w_kend   = (r_phase == PH_FAC || r_phase == PH_FWD) ? r_i : r_n;
        case (r_phase)
            PH_FAC:  w_init = 64'(r_a_q);
            PH_FWD:  w_init = 64'(r_b_q);
            PH_BCK:  w_init = 64'(r_v_q);
            PH_RES:  w_init = -64'(r_b_q);
            default: w_init = '0;
        endcase
        w_mac_a = (r_phase == PH_RES) ? r_a_q : r_u0_q;
        w_mac_b = (r_phase == PH_FAC) ? r_u1_q : r_v_q;
        w_mac_ctl.load = (r_state == S_LOAD);
        w_mac_ctl.mul  = (r_state == S_TMUL);
        w_mac_ctl.acc  = (r_state == S_TACC);
        w_mac_ctl.sub  = (r_phase != PH_RES);
    end

    // Next element after a value has been stored.
    always_comb begin
        w_adv_phase = r_phase;
        w_adv_i     = r_i;
        w_adv_j     = r_j;
        case (r_phase)
            PH_FAC: begin
                if (r_j + 1'b1 < r_n) begin
                    w_adv_j = r_j + 1'b1;
                end else if (r_i + 1'b1 < r_n) begin
                    w_adv_i = r_i + 1'b1;
                    w_adv_j = r_i + 1'b1;
                end else begin
                    w_adv_phase = PH_FWD;
                    w_adv_i     = '0;
                end
            end
            PH_FWD: begin
                if (r_i + 1'b1 < r_n) begin
                    w_adv_i = r_i + 1'b1;
                end else begin
                    w_adv_phase = PH_BCK;
                    w_adv_i     = r_n - 1'b1;
                end
            end
            PH_BCK: begin
                if (r_i != '0) begin
                    w_adv_i = r_i - 1'b1;
                end else begin
                    w_adv_phase = PH_RES;
                end
            end
            default: ;
        endcase
    end

    // Divider / square root start and the store writes it leads to.
    always_comb begin
        w_dsu_start = 1'b0;
        w_dsu_op    = DSU_DIV;
        if (r_state == S_FIN && r_phase == PH_FAC && r_i == r_j && !w_sat_nonpos) begin
            w_dsu_start = 1'b1;
            w_dsu_op    = DSU_SQRT;
        end else if (r_state == S_DGO) begin
            w_dsu_start = 1'b1;
        end
        w_u_waddr = f_addr(r_i, r_j);
        w_u_we    = 1'b0;
        w_u_wdata = w_dsu_res;
        w_v_we    = 1'b0;
        if (r_state == S_FIN && r_phase == PH_FAC && r_i == r_j && w_sat_nonpos) begin
            w_u_we    = 1'b1;
            w_u_wdata = '0;
        end else if (r_state == S_DWAIT && w_dsu_done) begin
            w_u_we = (r_phase == PH_FAC);
            w_v_we = (r_phase != PH_FAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_act == ACT_WR_MATRIX && int'(w_row) < MAX_DIM
                && int'(w_col) < MAX_DIM) begin
            r_mem_a[f_addr(CNT_W'(w_row), CNT_W'(w_col))] <= w_value;
        end
        if (w_in_acc && w_act == ACT_WR_RHS && int'(w_row) < MAX_DIM) begin
            r_mem_b[VW'(w_row)] <= w_value;
        end
        if (w_u_we) begin
            r_mem_u[w_u_waddr] <= w_u_wdata;
        end
        if (w_v_we) begin
            r_mem_v[VW'(r_i)] <= w_dsu_res;
        end
        r_a_q  <= r_mem_a[w_a_addr];
        r_u0_q <= r_mem_u[w_u0_addr];
        r_u1_q <= r_mem_u[w_u1_addr];
        r_b_q  <= r_mem_b[VW'(r_i)];
        r_v_q  <= r_mem_v[w_v_addr];
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_RESET;
            r_state   <= S_IDLE;
            r_phase   <= PH_FAC;
            r_m_valid <= 1'b0;
            r_flag    <= 1'b0;
            r_n       <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && w_act == ACT_START) begin
                        if (r_size == '0) begin
                            r_n <= CNT_W'(1);
                        end else if (int'(r_size) > N_CAP) begin
                            r_n <= CNT_W'(N_CAP);
                        end else begin
                            r_n <= CNT_W'(r_size);
                        end
                        r_flag  <= 1'b0;
                        r_phase <= PH_FAC;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_k     <= w_kstart;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= (r_k == w_kend) ? S_FIN : S_TRD;
                end
                S_TRD:  r_state <= S_TMUL;
                S_TMUL: r_state <= S_TACC;
                S_TACC: begin
                    r_k     <= w_k_inc;
                    r_state <= (w_k_inc == w_kend) ? S_FIN : S_TRD;
                end
                S_FIN: begin
                    if (r_phase == PH_RES) begin
                        r_state <= S_EMIT;
                    end else if (r_phase == PH_FAC && r_i == r_j) begin
                        if (w_sat_nonpos) begin
                            // Pivot not positive: diagonal is forced to zero.
                            r_flag  <= 1'b1;
                            r_phase <= w_adv_phase;
                            r_i     <= w_adv_i;
                            r_j     <= w_adv_j;
                            r_state <= S_INIT;
                        end else begin
                            r_state <= S_DWAIT;
                        end
                    end else begin
                        r_state <= S_DRD;
                    end
                end
                S_DRD: r_state <= S_DGO;
                S_DGO: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_dsu_done) begin
                        r_phase <= w_adv_phase;
                        r_i     <= w_adv_i;
                        r_j     <= w_adv_j;
                        r_state <= S_INIT;
                    end
                end
                S_EMIT: begin
                    r_m_valid <= 1'b1;
                    r_m_index <= r_i[2:0];
                    r_m_sol   <= r_v_q;
                    r_m_res   <= w_sat;
                    r_m_last  <= (r_i + 1'b1 == r_n);
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_m_valid <= 1'b0;
                        if (r_i + 1'b1 < r_n) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_INIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    chol_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_init (w_init),
        .i_a    (w_mac_a),
        .i_b    (w_mac_b),
        .o_sat  (w_sat)
    );

    chol_dsu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dsu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_dsu_start),
        .i_op     (w_dsu_op),
        .i_num    (w_sat),
        .i_den    (r_u0_q),
        .o_done   (w_dsu_done),
        .o_result (w_dsu_res)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'b0, r_m_res, r_m_sol, r_m_index};
    assign m_axis_tuser  = r_flag;
    assign m_axis_tlast  = r_m_last;

    // The input is never open while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // The divider only reports completion while the sequencer waits for it.
    a_dsu_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dsu_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside its wait state");

    // A start transaction closes the input on the following cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_act == ACT_START) |=> !s_axis_tready)
        else $error("input still open after start");

    // Taking the last result returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after the last result");

endmodule

>>> dv/tb_cholesky_linear_solver_unit.sv
// Self-checking testbench for cholesky_linear_solver_unit: directed table plus random solves.
// Depends on chol_pkg and the RTL of the block; predicts results from its own solver.
`timescale 1ns / 100ps

module tb_cholesky_linear_solver_unit import chol_pkg::*;;

    localparam int FRAC      = DEF_FRAC_BITS;
    localparam int NDIM      = DEF_MAX_DIM;
    localparam int ITEM_GOAL = 470;
    localparam int STALL_MAX = 20000;  // idle cycles allowed

    typedef struct {
        logic [2:0]  index;
        logic [31:0] solution;
        logic [31:0] residual;
        logic        not_positive;
        logic        last;
    } t_row_result;

    // One row of the directed table. A config write, when enabled, happens once the
    // block is idle and before the transaction of the same row.
    typedef struct {
        bit          cfg_en;
        logic [3:0]  cfg_val;
        t_action     act;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        bit          typed;
        logic [31:0] exp_sol;
        logic [31:0] exp_res;
        bit          exp_np;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [3:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // row[2:0], col[5:3], value[37:6], zero fill
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // index[2:0], solution[34:3], residual[66:35]
    logic [0:0]  m_axis_tuser;   // not_positive[0]
    logic        m_axis_tlast;

    cholesky_linear_solver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Solver shadow state, kept in step with every accepted transaction.
    int          mat_shadow [NDIM*NDIM];
    int          rhs_shadow [NDIM];
    int          u_shadow   [NDIM*NDIM];
    int          y_shadow   [NDIM];
    int          x_shadow   [NDIM];
    logic [3:0]  size_shadow;
    bit          mat_written [NDIM*NDIM];
    bit          rhs_written [NDIM];

    t_row_result pending_rows [$];
    t_row_result typed_rows   [$];  // typed-in expectations that replace predicted ones
    int          fails;
    int          n_items;
    int          n_solves;
    int          n_results;
    int          idle_cycles;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- arithmetic

    function automatic int sat_word(longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Exact product, rounded to nearest with ties toward +inf.
    function automatic longint fx_mul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic int fx_div(int num, int den);
        if (den == 0) begin
            if (num > 0) return 32'sh7FFF_FFFF;
            if (num < 0) return 32'sh8000_0000;
            return 0;
        end
        return sat_word((longint'(num) * (longint'(1) <<< FRAC)) / longint'(den));
    endfunction

    // Integer floor square root of v * 2^FRAC, digit by digit.
    function automatic int fx_sqrt(int v);
        longint unsigned r;
        longint unsigned res;
        longint unsigned b;
        r   = longint'(unsigned'(v)) << FRAC;
        res = 0;
        b   = 64'd1 << 62;
        while (b > r) b >>= 2;
        while (b != 0) begin
            if (r >= res + b) begin
                r  -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return int'(res);
    endfunction

    function automatic int dim_in_use(logic [3:0] sz);
        if (sz == 0) return 1;
        if (sz > NDIM) return NDIM;
        return int'(sz);
    endfunction

    // Runs one solve on the shadow stores and queues the n row results.
    task automatic solve_and_queue();
        int          n;
        longint      acc;
        int          s;
        bit          np;
        t_row_result r;
        n  = dim_in_use(size_shadow);
        np = 1'b0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (j < i) begin
                    u_shadow[i*NDIM+j] = 0;
                end else begin
                    acc = mat_shadow[i*NDIM+j];
                    for (int k = 0; k < i; k++)
                        acc -= fx_mul(u_shadow[k*NDIM+i], u_shadow[k*NDIM+j]);
                    s = sat_word(acc);
                    if (i == j) begin
                        if (s <= 0) begin
                            np = 1'b1;
                            u_shadow[i*NDIM+j] = 0;
                        end else begin
                            u_shadow[i*NDIM+j] = fx_sqrt(s);
                        end
                    end else begin
                        u_shadow[i*NDIM+j] = fx_div(s, u_shadow[i*NDIM+i]);
                    end
                end
            end
        end
        // Forward substitution through U transposed.
        for (int i = 0; i < n; i++) begin
            acc = rhs_shadow[i];
            for (int k = 0; k < i; k++)
                acc -= fx_mul(u_shadow[k*NDIM+i], y_shadow[k]);
            y_shadow[i] = fx_div(sat_word(acc), u_shadow[i*NDIM+i]);
        end
        // Back substitution, last row first.
        for (int i = n - 1; i >= 0; i--) begin
            acc = y_shadow[i];
            for (int k = n - 1; k > i; k--)
                acc -= fx_mul(u_shadow[i*NDIM+k], x_shadow[k]);
            x_shadow[i] = fx_div(sat_word(acc), u_shadow[i*NDIM+i]);
        end
        for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++)
                acc += fx_mul(mat_shadow[i*NDIM+j], x_shadow[j]);
            acc -= rhs_shadow[i];
            r.index        = 3'(i);
            r.solution     = x_shadow[i];
            r.residual     = sat_word(acc);
            r.not_positive = np;
            r.last         = (i == n - 1);
            if (typed_rows.size() > 0) begin
                r = typed_rows.pop_front();
            end
            pending_rows.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------- driving

    // Presents one transaction from a falling edge and holds it until accepted.
    // Before that, outside the calm stretch, the sender idles each cycle with a chance of about a quarter.
    task automatic send_item(t_action act, logic [2:0] row, logic [2:0] col,
                             logic [31:0] value);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 26) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {2'b00, value, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        // Accepted at this edge: update the shadow state.
        case (act)
            ACT_WR_MATRIX: begin
                mat_shadow[row*NDIM+col]  = value;
                mat_written[row*NDIM+col] = 1'b1;
            end
            ACT_WR_RHS: begin
                rhs_shadow[row]  = value;
                rhs_written[row] = 1'b1;
            end
            ACT_START: begin
                solve_and_queue();
                n_solves++;
            end
            default: ;
        endcase
        if (act != ACT_NONE) n_items++;
    endtask

    // Waits until all results are back, lets the block settle, then writes the size.
    task automatic write_size(logic [3:0] sz);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = sz;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        size_shadow   = sz;
    endtask

    // Writes every entry a solve at the current size reads that was never written.
    task automatic fill_unwritten();
        int n;
        n = dim_in_use(size_shadow);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++)
                if (!mat_written[i*NDIM+j])
                    send_item(ACT_WR_MATRIX, 3'(i), 3'(j), $urandom);
            if (!rhs_written[i])
                send_item(ACT_WR_RHS, 3'(i), 3'($urandom), $urandom);
        end
    endtask

    // A well-conditioned symmetric system: small off-diagonal terms and a diagonal
    // large enough to keep every pivot positive.
    task automatic load_dominant_system();
        int          n;
        logic [31:0] v;
        n = dim_in_use(size_shadow);
        for (int i = 0; i < n; i++) begin
            for (int j = i; j < n; j++) begin
                if (i == j) begin
                    v = $urandom_range(64 << FRAC, n << FRAC);
                    send_item(ACT_WR_MATRIX, 3'(i), 3'(i), v);
                end else begin
                    v = int'($urandom_range(2 << FRAC)) - (1 << FRAC);
                    send_item(ACT_WR_MATRIX, 3'(i), 3'(j), v);
                    send_item(ACT_WR_MATRIX, 3'(j), 3'(i), v);
                end
            end
            v = int'($urandom_range(32 << FRAC)) - (16 << FRAC);
            send_item(ACT_WR_RHS, 3'(i), 3'($urandom), v);
        end
    endtask

    // The receiver stalls about a quarter of the time, except in the calm stretch.
    always @(negedge i_clk) begin
        calm          = (n_items >= 200 && n_items < 300);
        m_axis_tready = calm || ($urandom_range(99) >= 26);
    end

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin
        t_row_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_rows.size() == 0) begin
                $error("result transaction with no expectation waiting: index %0d",
                       m_axis_tdata[2:0]);
                fails++;
            end else begin
                want = pending_rows.pop_front();
                if (m_axis_tdata[2:0] !== want.index) begin
                    $error("index: expected %0d, actual %0d", want.index, m_axis_tdata[2:0]);
                    fails++;
                end
                if (m_axis_tdata[34:3] !== want.solution) begin
                    $error("solution: expected %h, actual %h", want.solution,
                           m_axis_tdata[34:3]);
                    fails++;
                end
                if (m_axis_tdata[66:35] !== want.residual) begin
                    $error("residual: expected %h, actual %h", want.residual,
                           m_axis_tdata[66:35]);
                    fails++;
                end
                if (m_axis_tuser[0] !== want.not_positive) begin
                    $error("not_positive: expected %b, actual %b", want.not_positive,
                           m_axis_tuser[0]);
                    fails++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, m_axis_tlast);
                    fails++;
                end
            end
        end
    end

    // Watchdog: the run ends when neither side has moved for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    t_dir_row dir_rows [20] = '{
        // Size 1: identity-like scalar, then a zero pivot, then a negative pivot.
        '{1, 4'd1, ACT_WR_MATRIX, 3'd0, 3'd0, 32'h0001_0000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_WR_RHS,    3'd0, 3'd5, 32'h0002_0000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_START,     3'd0, 3'd0, 32'h0,         1, 32'h0002_0000, 32'h0, 0},
        '{0, 4'd0, ACT_WR_MATRIX, 3'd0, 3'd0, 32'h0,         0, 0, 0, 0},
        '{0, 4'd0, ACT_START,     3'd7, 3'd7, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF,
          32'hFFFE_0000, 1},
        '{0, 4'd0, ACT_WR_MATRIX, 3'd0, 3'd0, 32'hFFFF_0000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_WR_RHS,    3'd0, 3'd0, 32'h0,         0, 0, 0, 0},
        '{0, 4'd0, ACT_START,     3'd0, 3'd0, 32'h0,         1, 32'h0, 32'h0, 1},
        // Extremes of the value field.
        '{0, 4'd0, ACT_WR_MATRIX, 3'd0, 3'd0, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{0, 4'd0, ACT_WR_RHS,    3'd0, 3'd0, 32'h8000_0000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_START,     3'd0, 3'd0, 32'h0,         0, 0, 0, 0},
        // The unused action must do nothing.
        '{0, 4'd0, ACT_NONE,      3'd7, 3'd7, 32'hFFFF_FFFF, 0, 0, 0, 0},
        // Size 0 behaves as 1: 4.0 x = 1.0 gives x = 0.25.
        '{1, 4'd0, ACT_WR_MATRIX, 3'd0, 3'd0, 32'h0004_0000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_WR_RHS,    3'd0, 3'd0, 32'h0001_0000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_START,     3'd0, 3'd0, 32'h0,         1, 32'h0000_4000, 32'h0, 0},
        // Size 2 with off-diagonal terms.
        '{1, 4'd2, ACT_WR_MATRIX, 3'd0, 3'd1, 32'h0000_8000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_WR_MATRIX, 3'd1, 3'd0, 32'h0000_8000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_WR_MATRIX, 3'd1, 3'd1, 32'h0002_0000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_WR_RHS,    3'd1, 3'd0, 32'hFFFF_0000, 0, 0, 0, 0},
        '{0, 4'd0, ACT_START,     3'd0, 3'd0, 32'h0,         0, 0, 0, 0}
    };

    initial begin
        t_row_result typed;
        int          pick;
        logic [3:0]  sz;
        fails         = 0;
        n_items       = 0;
        n_solves      = 0;
        n_results     = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        size_shadow   = SIZE_RESET;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_NONE;
        m_axis_tready = 1'b0;
        foreach (mat_written[k]) mat_written[k] = 1'b0;
        foreach (rhs_written[k]) rhs_written[k] = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table. Typed rows all solve a size-1 system (size 0 acts as 1), so one result each.
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_en) write_size(dir_rows[r].cfg_val);
            if (dir_rows[r].typed) begin
                typed.index        = 3'd0;
                typed.solution     = dir_rows[r].exp_sol;
                typed.residual     = dir_rows[r].exp_res;
                typed.not_positive = dir_rows[r].exp_np;
                typed.last         = 1'b1;
                typed_rows.push_back(typed);
            end
            send_item(dir_rows[r].act, dir_rows[r].row, dir_rows[r].col, dir_rows[r].value);
        end

        // Random solves: mostly well-conditioned systems, some raw noise. Large sizes,
        // including the out-of-range codes above 8, come up now and then.
        while (n_items < ITEM_GOAL) begin
            pick = $urandom_range(99);
            if (pick < 55)      sz = 4'($urandom_range(3, 1));
            else if (pick < 80) sz = 4'($urandom_range(6, 4));
            else if (pick < 90) sz = 4'($urandom_range(15, 7));
            else                sz = 4'd0;
            if (sz != size_shadow || $urandom_range(3) == 0) write_size(sz);
            if ($urandom_range(99) < 70) begin
                load_dominant_system();
            end else begin
                repeat ($urandom_range(8)) begin
                    pick = $urandom_range(9);
                    if (pick < 5)
                        send_item(ACT_WR_MATRIX, 3'($urandom), 3'($urandom), $urandom);
                    else if (pick < 8)
                        send_item(ACT_WR_RHS, 3'($urandom), 3'($urandom), $urandom);
                    else
                        send_item(ACT_NONE, 3'($urandom), 3'($urandom), $urandom);
                end
            end
            fill_unwritten();
            send_item(ACT_START, 3'($urandom), 3'($urandom), $urandom);
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);

        $display("Covered %0d load and start transactions, %0d solves and %0d row results,",
                 n_items, n_solves, n_results);
        $display("with sizes 0 to 15, pivots not positive, saturation and both-side stalls.");
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
